### sv/bcc_pkg.sv
// Shared types, constants and helper functions for the balance cascade controller.
// Used by the serial multiplier, the serial divider and the top level; depends on nothing.
package bcc_pkg;

    // Internal working width: holds the largest gain product with margin.
    localparam int W      = 50;
    localparam int GAIN_W = 16;

    typedef logic signed [W-1:0] t_word;

    localparam t_word ANGLE_D_LIM = t_word'(196608);    // 3.0 degrees in Q16.16
    localparam t_word ANGLE_I_LIM = t_word'(1966080);   // 30.0 degrees in Q16.16
    localparam t_word TILT_DIFF   = t_word'(3840);      // 30 degrees in 1/128 degree
    localparam t_word TURN_LIM    = t_word'(960);
    localparam t_word ERR_LIM     = t_word'(32767);
    localparam t_word DISP_LIM    = t_word'(520);
    localparam t_word SPEED_LIM   = t_word'(180);
    localparam t_word DRIVE_LIM   = t_word'(524288000); // 8000.0 in Q16.16

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        ST_FRONT,
        ST_BKP,
        ST_BKI,
        ST_BKI_DIV,
        ST_BKD,
        ST_SF_DIV,
        ST_SKP,
        ST_SKP_DIV,
        ST_SKI,
        ST_SKI_DIV,
        ST_TARGET,
        ST_WA_P,
        ST_WA_I,
        ST_WA_DIV,
        ST_WB_P,
        ST_WB_I,
        ST_WB_DIV,
        ST_END
    } t_step;

    typedef enum logic [2:0] {
        REG_ZERO_POINT = 3'd0,
        REG_BALANCE_KP = 3'd1,
        REG_BALANCE_KI = 3'd2,
        REG_BALANCE_KD = 3'd3,
        REG_SPEED_KP   = 3'd4,
        REG_SPEED_KI   = 3'd5,
        REG_WHEEL_KP   = 3'd6,
        REG_WHEEL_KI   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_5,
        DIV_10,
        DIV_100
    } t_div_sel;

    typedef struct packed {
        logic              start;
        t_word             operand;
        logic [GAIN_W-1:0] gain;
    } t_mul_req;

    typedef struct packed {
        logic     start;
        t_word    dividend;
        t_div_sel sel;
    } t_div_req;

    function automatic logic [6:0] div_const(t_div_sel sel);
        logic [6:0] k;
        unique case (sel)
            DIV_5:   k = 7'd5;
            DIV_10:  k = 7'd10;
            DIV_100: k = 7'd100;
            default: k = 7'd5;
        endcase
        return k;
    endfunction

    // Symmetric saturation to +-lim.
    function automatic t_word sat(t_word x, t_word lim);
        t_word y;
        y = x;
        if (x > lim) y = lim;
        else if (x < -lim) y = -lim;
        return y;
    endfunction

    // Division by a power of two that truncates toward zero.
    function automatic t_word trunc_shr(t_word x, int unsigned k);
        t_word m;
        m = (x < 0) ? -x : x;
        m = m >>> k;
        return (x < 0) ? -m : m;
    endfunction

endpackage

### sv/balance_cascade_controller_core.sv
// Cascaded balance controller for a two-wheel robot: angle PID, speed PI with low-pass filter
// and displacement integral, and two incremental wheel PI loops, computed by a step sequencer
// around one serial multiplier (each product step: start, 16 gain bits, handoff) and one
// serial constant divider (each quotient step: start, 50 quotient bits, handoff). A tick
// that runs the loops has nine product steps and six quotient steps; a disabled or tilted
// tick skips them all. One tick is worked at a time; the result sits in an output register
// so the next tick can be taken while it waits.
// Depends on bcc_pkg, bcc_mul and bcc_div.
module balance_cascade_controller_core import bcc_pkg::*; #(
    parameter int MOTOR_LIMIT = 5268,
    parameter int TILT_TICKS  = 50
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_encoder_a,
    input  logic signed [15:0] i_encoder_b,
    input  logic signed [10:0] i_drive_speed,
    input  logic signed [10:0] i_turn_rate,
    input  logic               i_enable,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [13:0] o_motor_a,
    output logic signed [13:0] o_motor_b,
    output logic               o_tipped_over
);

    // Configuration registers.
    logic signed [15:0] r_zero;
    logic [15:0] r_bkp, r_bki, r_bkd, r_skp, r_ski, r_wkp, r_wki;

    // Captured input item.
    logic signed [15:0] r_pitch, r_enc_a, r_enc_b;
    logic signed [10:0] r_dspeed, r_turn;
    logic               r_en;

    // Loop state.
    logic signed [22:0] r_ang_last, r_ang_int;
    logic signed [32:0] r_spd_filt;
    logic signed [10:0] r_disp;
    logic signed [30:0] r_wa_drive, r_wb_drive;
    logic signed [18:0] r_wa_last, r_wb_last;
    logic [5:0]         r_tilt;
    logic signed [13:0] r_held_a, r_held_b;
    logic               r_tip;

    // Per-tick temporaries.
    logic signed [22:0] r_b, r_d;
    logic signed [16:0] r_e;
    logic signed [8:0]  r_s;
    logic signed [18:0] r_err_a, r_err_b;
    t_word              r_v, r_t1, r_sacc, r_acc;

    // Sequencer.
    t_state r_state, n_state;
    t_step  r_step;
    logic   r_busy;

    // Output register.
    logic               r_out_valid;
    logic signed [13:0] r_motor_a, r_motor_b;
    logic               r_tip_out;

    logic     w_accept, w_load_out, w_run;
    logic     w_is_mul, w_is_div, w_unit_done;
    t_mul_req w_mul_req;
    t_div_req w_div_req;
    logic     w_mul_done, w_div_done;
    t_word    w_mul_p, w_div_q;

    logic signed [16:0] w_diff;
    logic               w_tilt;
    logic [5:0]         w_tilt_n;
    t_word w_b, w_d, w_int, w_n, w_e, w_disp, w_x, w_z, w_sx;
    t_word w_ta, w_tb, w_err_a, w_err_b, w_drv;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero <= 16'sd0;
            r_bkp  <= 16'd3328;
            r_bki  <= 16'd0;
            r_bkd  <= 16'd35840;
            r_skp  <= 16'd3584;
            r_ski  <= 16'd1024;
            r_wkp  <= 16'd5120;
            r_wki  <= 16'd25600;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ZERO_POINT: r_zero <= $signed(i_cfg_data);
                REG_BALANCE_KP: r_bkp  <= i_cfg_data;
                REG_BALANCE_KI: r_bki  <= i_cfg_data;
                REG_BALANCE_KD: r_bkd  <= i_cfg_data;
                REG_SPEED_KP:   r_skp  <= i_cfg_data;
                REG_SPEED_KI:   r_ski  <= i_cfg_data;
                REG_WHEEL_KP:   r_wkp  <= i_cfg_data;
                REG_WHEEL_KI:   r_wki  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_RUN;
            S_RUN:  if (r_step == ST_END) n_state = S_DONE;
            S_DONE: if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_load_out = 1'b0;
        w_run      = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_RUN:  w_run = 1'b1;
            S_DONE: w_load_out = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // ---------------- combinational helpers ----------------
    always_comb begin
        w_diff   = $signed({r_pitch[15], r_pitch}) - $signed({r_zero[15], r_zero});
        w_tilt   = (t_word'(w_diff) >= TILT_DIFF) || (t_word'(w_diff) <= -TILT_DIFF);
        w_tilt_n = (r_tilt < 6'd63) ? r_tilt + 6'd1 : r_tilt;
        w_b      = t_word'(w_diff) <<< 9;
        w_d      = sat(w_b - t_word'(r_ang_last), ANGLE_D_LIM);
        w_int    = sat(t_word'(r_ang_int) + w_b, ANGLE_I_LIM);
        // Speed error in eighths of a count, truncated to whole counts.
        w_n      = ((t_word'(r_enc_a) + t_word'(r_enc_b)) <<< 3) - t_word'(r_dspeed);
        w_e      = sat(trunc_shr(w_n, 3), ERR_LIM);
        w_disp   = sat(t_word'(r_disp) + w_e, DISP_LIM);
        w_x      = t_word'(r_dspeed) <<< 12;
        w_z      = sat(t_word'(r_turn), TURN_LIM) <<< 12;
        w_sx     = r_v + (t_word'(r_s) <<< 16) + w_x;
        w_ta     = trunc_shr(w_sx + w_z, 16);
        w_tb     = trunc_shr(w_sx - w_z, 16);
        w_err_a  = w_ta - t_word'(r_enc_a);
        w_err_b  = w_tb - t_word'(r_enc_b);
        w_drv    = sat(r_acc + w_div_q, DRIVE_LIM);
    end

    // ---------------- unit requests ----------------
    always_comb begin
        w_is_mul = 1'b0;
        w_is_div = 1'b0;
        case (r_step) inside
            ST_BKP, ST_BKI, ST_BKD, ST_SKP, ST_SKI,
            ST_WA_P, ST_WA_I, ST_WB_P, ST_WB_I:              w_is_mul = 1'b1;
            ST_BKI_DIV, ST_SF_DIV, ST_SKP_DIV, ST_SKI_DIV,
            ST_WA_DIV, ST_WB_DIV:                            w_is_div = 1'b1;
            default: ;
        endcase
        w_unit_done = w_is_mul ? w_mul_done : w_div_done;

        w_mul_req         = '0;
        w_mul_req.start   = w_run && !r_busy && w_is_mul;
        w_div_req         = '0;
        w_div_req.start   = w_run && !r_busy && w_is_div;
        w_div_req.dividend = r_t1;
        w_div_req.sel     = DIV_100;
        unique case (r_step)
            ST_BKP:  begin w_mul_req.gain = r_bkp; w_mul_req.operand = t_word'(r_b); end
            ST_BKI:  begin w_mul_req.gain = r_bki; w_mul_req.operand = t_word'(r_ang_int); end
            ST_BKD:  begin w_mul_req.gain = r_bkd; w_mul_req.operand = t_word'(r_d); end
            ST_SKP:  begin w_mul_req.gain = r_skp; w_mul_req.operand = t_word'(r_spd_filt); end
            ST_SKI:  begin w_mul_req.gain = r_ski; w_mul_req.operand = t_word'(r_disp); end
            ST_WA_P: begin
                w_mul_req.gain    = r_wkp;
                w_mul_req.operand = t_word'(r_err_a) - t_word'(r_wa_last);
            end
            ST_WA_I: begin w_mul_req.gain = r_wki; w_mul_req.operand = t_word'(r_err_a); end
            ST_WB_P: begin
                w_mul_req.gain    = r_wkp;
                w_mul_req.operand = t_word'(r_err_b) - t_word'(r_wb_last);
            end
            ST_WB_I: begin w_mul_req.gain = r_wki; w_mul_req.operand = t_word'(r_err_b); end
            ST_BKI_DIV, ST_SKP_DIV: w_div_req.sel = DIV_10;
            ST_SF_DIV: begin
                w_div_req.sel      = DIV_5;
                w_div_req.dividend = (t_word'(r_spd_filt) <<< 2) + (t_word'(r_e) <<< 16);
            end
            default: ;
        endcase
    end

    bcc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mul_req),
        .o_done    (w_mul_done),
        .o_product (w_mul_p)
    );

    bcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // ---------------- sequencer and loop state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= ST_FRONT;
            r_busy     <= 1'b0;
            r_ang_last <= '0;
            r_ang_int  <= '0;
            r_spd_filt <= '0;
            r_disp     <= '0;
            r_wa_drive <= '0;
            r_wb_drive <= '0;
            r_wa_last  <= '0;
            r_wb_last  <= '0;
            r_tilt     <= '0;
            r_held_a   <= '0;
            r_held_b   <= '0;
            r_tip      <= 1'b0;
        end else if (w_accept) begin
            r_step <= ST_FRONT;
            r_busy <= 1'b0;
        end else if (w_run) begin
            if (w_mul_req.start || w_div_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_unit_done) begin
                r_busy <= 1'b0;
                r_step <= t_step'(r_step + 5'd1);
                unique case (r_step)
                    ST_BKP:     r_v <= r_v - trunc_shr(w_mul_p, 8);
                    ST_BKI:     r_t1 <= trunc_shr(w_mul_p, 8);
                    ST_BKI_DIV: r_v <= r_v - w_div_q;
                    ST_BKD:     r_v <= r_v - trunc_shr(w_mul_p, 8);
                    ST_SF_DIV:  r_spd_filt <= 33'(w_div_q);
                    ST_SKP:     r_t1 <= trunc_shr(w_mul_p, 8);
                    ST_SKP_DIV: r_sacc <= w_div_q;
                    ST_SKI:     r_t1 <= w_mul_p <<< 8;
                    ST_SKI_DIV: r_s <= 9'(sat(trunc_shr(r_sacc + w_div_q, 16), SPEED_LIM));
                    ST_WA_P:    r_acc <= t_word'(r_wa_drive) + (w_mul_p <<< 8);
                    ST_WB_P:    r_acc <= t_word'(r_wb_drive) + (w_mul_p <<< 8);
                    ST_WA_I, ST_WB_I: r_t1 <= w_mul_p <<< 8;
                    ST_WA_DIV: begin
                        r_wa_drive <= 31'(w_drv);
                        r_wa_last  <= r_err_a;
                        r_held_a   <= 14'(sat(trunc_shr(w_drv, 16), t_word'(MOTOR_LIMIT)));
                    end
                    ST_WB_DIV: begin
                        r_wb_drive <= 31'(w_drv);
                        r_wb_last  <= r_err_b;
                        r_held_b   <= 14'(sat(trunc_shr(w_drv, 16), t_word'(MOTOR_LIMIT)));
                    end
                    default: ;
                endcase
            end else if (r_step == ST_FRONT) begin
                if (!r_en) begin
                    r_ang_last <= '0;
                    r_ang_int  <= '0;
                    r_spd_filt <= '0;
                    r_disp     <= '0;
                    r_wa_drive <= '0;
                    r_wb_drive <= '0;
                    r_wa_last  <= '0;
                    r_wb_last  <= '0;
                    r_held_a   <= '0;
                    r_held_b   <= '0;
                    r_tip      <= 1'b0;
                    r_step     <= ST_END;
                end else if (w_tilt) begin
                    // Loops are frozen; the held outputs repeat until the tilt runs too long.
                    r_tilt <= w_tilt_n;
                    r_step <= ST_END;
                    if (w_tilt_n > 6'(TILT_TICKS)) begin
                        r_held_a <= '0;
                        r_held_b <= '0;
                        r_tip    <= 1'b1;
                    end else begin
                        r_tip <= 1'b0;
                    end
                end else begin
                    r_b        <= 23'(w_b);
                    r_d        <= 23'(w_d);
                    r_ang_last <= 23'(w_b);
                    r_ang_int  <= 23'(w_int);
                    r_e        <= 17'(w_e);
                    r_disp     <= 11'(w_disp);
                    r_v        <= '0;
                    r_tilt     <= '0;
                    r_tip      <= 1'b0;
                    r_step     <= ST_BKP;
                end
            end else if (r_step == ST_TARGET) begin
                r_err_a <= 19'(w_err_a);
                r_err_b <= 19'(w_err_b);
                r_step  <= ST_WA_P;
            end
        end
    end

    // ---------------- input capture ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pitch  <= i_pitch_angle;
            r_enc_a  <= i_encoder_a;
            r_enc_b  <= i_encoder_b;
            r_dspeed <= i_drive_speed;
            r_turn   <= i_turn_rate;
            r_en     <= i_enable;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_motor_a <= r_held_a;
            r_motor_b <= r_held_b;
            r_tip_out <= r_tip;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_motor_a     = r_motor_a;
    assign o_motor_b     = r_motor_b;
    assign o_tipped_over = r_tip_out;

endmodule

### sv/bcc_mul.sv
// Serial shift-add multiplier: unsigned 16-bit gain times a signed operand, one gain bit per cycle.
// Depends on bcc_pkg for the word type and the request struct.
module bcc_mul import bcc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output logic     o_done,
    output t_word    o_product
);

    localparam int CNT_W = $clog2(GAIN_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    t_word             r_acc;
    t_word             r_opnd;
    logic [GAIN_W-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc  <= '0;
            r_opnd <= i_req.operand;
            r_gain <= i_req.gain;
        end else if (r_busy) begin
            if (r_gain[0]) r_acc <= r_acc + r_opnd;
            r_opnd <= r_opnd <<< 1;
            r_gain <= r_gain >> 1;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

### sv/bcc_div.sv
// Serial restoring divider by a small constant (5, 10 or 100), one quotient bit per cycle,
// truncating toward zero. Depends on bcc_pkg for the word type, divisor codes and request struct.
module bcc_div import bcc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output logic     o_done,
    output t_word    o_quot
);

    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_num;
    logic [W-1:0]     r_quo;
    logic [6:0]       r_rem;
    logic [6:0]       r_k;
    logic             r_neg;

    logic [7:0] w_trial;
    logic       w_ge;

    // The remainder stays below the divisor, so the trial value fits in eight bits.
    assign w_trial = {r_rem, r_num[W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_k});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[W-1];
            r_num <= i_req.dividend[W-1] ? -i_req.dividend : i_req.dividend;
            r_quo <= '0;
            r_rem <= '0;
            r_k   <= div_const(i_req.sel);
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_quo <= {r_quo[W-2:0], w_ge};
            r_rem <= w_ge ? 7'(w_trial - {1'b0, r_k}) : w_trial[6:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

### test/tb_balance_cascade_controller_core.sv
// Self-checking testbench for balance_cascade_controller_core: directed and random control ticks
// over several register settings, each result checked against a cycle-free predictor.
// Depends on bcc_pkg and the controller RTL.
module tb_balance_cascade_controller_core;
    import bcc_pkg::*;

    localparam int  MOTOR_LIM  = 5268;
    localparam int  TILT_LIM   = 50;
    localparam int  CYCLE_CAP  = 4000000;
    localparam int  LONG_HOLD  = 3000;

    typedef struct {
        logic signed [13:0] motor_a;
        logic signed [13:0] motor_b;
        logic               tipped;
    } t_drive_out;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = 3'd0;
    logic [15:0]        i_cfg_data = 16'd0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_pitch_angle = '0;
    logic signed [15:0] i_encoder_a = '0;
    logic signed [15:0] i_encoder_b = '0;
    logic signed [10:0] i_drive_speed = '0;
    logic signed [10:0] i_turn_rate = '0;
    logic               i_enable = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [13:0] o_motor_a;
    logic signed [13:0] o_motor_b;
    logic               o_tipped_over;

    balance_cascade_controller_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor copy of the registers and the loop state.
    longint gain_zero, gain_bkp, gain_bki, gain_bkd, gain_skp, gain_ski, gain_wkp, gain_wki;
    longint ang_last, ang_integ, spd_filt, disp_integ;
    longint whl_a_drive, whl_a_last, whl_b_drive, whl_b_last;
    longint held_a, held_b;
    int     tilt_ticks;

    t_drive_out drive_expq[$];
    int  n_ticks = 0, n_checked = 0, n_tipped = 0, n_errors = 0;
    int  burst_left = 0;
    int  cycle_count = 0;
    bit  hold_request = 1'b0;

    function automatic longint limit_to(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic longint wheel_update(longint target, longint enc, inout longint drive,
                                            inout longint last);
        longint err;
        err   = target - enc;
        drive = limit_to(drive + gain_wkp * (err - last) * 256 + (gain_wki * err * 256) / 100,
                         longint'(8000) * 65536);
        last  = err;
        return limit_to(drive / 65536, MOTOR_LIM);
    endfunction

    function automatic void clear_loop_state();
        ang_last = 0; ang_integ = 0; spd_filt = 0; disp_integ = 0;
        whl_a_drive = 0; whl_a_last = 0; whl_b_drive = 0; whl_b_last = 0;
        held_a = 0; held_b = 0;
    endfunction

    function automatic t_drive_out balance_tick(longint pitch, longint enc_a, longint enc_b,
                                                longint dspeed, longint turn, bit en);
        t_drive_out r;
        longint diff, b, d, v, x, z, e, s, ta, tb;
        r.motor_a = '0; r.motor_b = '0; r.tipped = 1'b0;
        if (!en) begin
            clear_loop_state();
            return r;
        end
        diff = pitch - gain_zero;
        if (diff < 3840 && diff > -3840) begin
            b = diff * 512;
            d = limit_to(b - ang_last, 3 * 65536);
            ang_integ = limit_to(ang_integ + b, 30 * 65536);
            v = -((gain_bkp * b) / 256 + (gain_bki * ang_integ) / 2560 + (gain_bkd * d) / 256);
            ang_last = b;
            x = dspeed * 4096;
            z = limit_to(turn, 960) * 4096;
            e = limit_to(((enc_a + enc_b) * 65536 - 2 * x) / 65536, 32767);
            spd_filt = (4 * spd_filt + e * 65536) / 5;
            disp_integ = limit_to(disp_integ + e, 520);
            s = limit_to(((gain_skp * spd_filt) / 2560 + (disp_integ * gain_ski * 256) / 100)
                         / 65536, 180);
            ta = (v + s * 65536 + x + z) / 65536;
            tb = (v + s * 65536 + x - z) / 65536;
            held_a = wheel_update(ta, enc_a, whl_a_drive, whl_a_last);
            held_b = wheel_update(tb, enc_b, whl_b_drive, whl_b_last);
            tilt_ticks = 0;
        end else if (tilt_ticks < 63) begin
            tilt_ticks++;
        end
        if (tilt_ticks > TILT_LIM) begin
            held_a = 0;
            held_b = 0;
            r.tipped = 1'b1;
        end
        r.motor_a = held_a[13:0];
        r.motor_b = held_b[13:0];
        return r;
    endfunction

    // Sender: bursts of transfers separated by random gaps. Called and returns at a falling edge.
    task automatic send_tick(input logic signed [15:0] pitch, input logic signed [15:0] enc_a,
                             input logic signed [15:0] enc_b, input logic signed [10:0] dspeed,
                             input logic signed [10:0] turn, input logic en);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 500) : $urandom_range(0, 20);
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_pitch_angle = pitch;
        i_encoder_a   = enc_a;
        i_encoder_b   = enc_b;
        i_drive_speed = dspeed;
        i_turn_rate   = turn;
        i_enable      = en;
        i_in_valid    = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        drive_expq.push_back(balance_tick(longint'(pitch), longint'(enc_a), longint'(enc_b),
                                          longint'(dspeed), longint'(turn), en));
        n_ticks++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        i_in_valid = 1'b0;
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_ZERO_POINT: gain_zero = longint'($signed(value));
            REG_BALANCE_KP: gain_bkp = longint'(value);
            REG_BALANCE_KI: gain_bki = longint'(value);
            REG_BALANCE_KD: gain_bkd = longint'(value);
            REG_SPEED_KP:   gain_skp = longint'(value);
            REG_SPEED_KI:   gain_ski = longint'(value);
            REG_WHEEL_KP:   gain_wkp = longint'(value);
            default:        gain_wki = longint'(value);
        endcase
    endtask

    // Every tick gives a result, so an empty queue means the block is idle.
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (drive_expq.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic load_gains(input int zp, input int bkp, input int bki, input int bkd,
                              input int skp, input int ski, input int wkp, input int wki);
        wait_idle();
        write_reg(REG_ZERO_POINT, zp[15:0]);
        write_reg(REG_BALANCE_KP, bkp[15:0]);
        write_reg(REG_BALANCE_KI, bki[15:0]);
        write_reg(REG_BALANCE_KD, bkd[15:0]);
        write_reg(REG_SPEED_KP, skp[15:0]);
        write_reg(REG_SPEED_KI, ski[15:0]);
        write_reg(REG_WHEEL_KP, wkp[15:0]);
        write_reg(REG_WHEEL_KI, wki[15:0]);
    endtask

    function automatic int pitch_balanced();
        int p;
        p = int'(gain_zero) + $urandom_range(0, 7678) - 3839;
        if (p > 23040) p = 23040;
        if (p < -23040) p = -23040;
        return p;
    endfunction

    function automatic int pitch_tilted();
        int p;
        do p = $urandom_range(0, 46080) - 23040;
        while (p - int'(gain_zero) < 3840 && p - int'(gain_zero) > -3840);
        return p;
    endfunction

    function automatic logic [15:0] rand_encoder();
        int v;
        if ($urandom_range(0, 4) != 0) begin
            v = $urandom_range(0, 400) - 200;
            return v[15:0];
        end
        return 16'($urandom());
    endfunction

    task automatic send_mixed(input int kind_roll);
        int p;
        logic en;
        en = 1'b1;
        if (kind_roll < 8) begin
            en = 1'b0;
            p = $urandom_range(0, 46080) - 23040;
        end else if (kind_roll < 15) begin
            p = pitch_tilted();
        end else begin
            p = pitch_balanced();
        end
        send_tick(p[15:0], rand_encoder(), rand_encoder(), 11'($urandom()), 11'($urandom()), en);
    endtask

    // Directed: field extremes, the tilt threshold on both sides, and disabled ticks.
    task automatic test_directed();
        send_tick(16'sd0, 16'sd0, 16'sd0, 11'sd0, 11'sd0, 1'b1);
        send_tick(16'sd3839, 16'sd0, 16'sd0, 11'sd0, 11'sd0, 1'b1);
        send_tick(-16'sd3839, 16'sd0, 16'sd0, 11'sd0, 11'sd0, 1'b1);
        send_tick(16'sd3840, 16'sd5, 16'sd5, 11'sd3, 11'sd3, 1'b1);
        send_tick(-16'sd3840, 16'sd5, 16'sd5, 11'sd3, 11'sd3, 1'b1);
        send_tick(16'sd23040, 16'sd0, 16'sd0, 11'sd0, 11'sd0, 1'b1);
        send_tick(-16'sd23040, 16'sd0, 16'sd0, 11'sd0, 11'sd0, 1'b1);
        send_tick(16'sd100, 16'sh7FFF, 16'sh7FFF, 11'sh3FF, 11'sh3FF, 1'b1);
        send_tick(-16'sd100, 16'sh8000, 16'sh8000, 11'sh400, 11'sh400, 1'b1);
        send_tick(16'sd50, 16'sh7FFF, 16'sh8000, -11'sd960, 11'sd960, 1'b1);
        send_tick(16'sd50, 16'sd10, -16'sd10, 11'sd0, 11'sd961, 1'b1);
        send_tick(16'sd50, 16'sd10, -16'sd10, 11'sd0, -11'sd961, 1'b1);
        send_tick(-16'sd1, -16'sd1, -16'sd1, -11'sd1, -11'sd1, 1'b1);
        send_tick(16'sd1000, 16'sd300, 16'sd300, 11'sd0, 11'sd0, 1'b0);
        send_tick(16'sd1000, 16'sd300, 16'sd300, 11'sd0, 11'sd0, 1'b1);
        send_tick(16'sh5A00, 16'sh5555, 16'shAAAA, 11'sh2AA, 11'sh555, 1'b0);
    endtask

    // Tilt held long enough to tip over, then recovery, then a disable clears everything.
    task automatic test_tip_over();
        int p, n;
        n = TILT_LIM + $urandom_range(1, 16);
        for (int k = 0; k < n; k++) begin
            p = pitch_tilted();
            send_tick(p[15:0], rand_encoder(), rand_encoder(), 11'($urandom()), 11'($urandom()),
                      1'b1);
        end
        for (int k = 0; k < 4; k++) begin
            p = pitch_balanced();
            send_tick(p[15:0], rand_encoder(), rand_encoder(), 11'($urandom()), 11'($urandom()),
                      1'b1);
        end
        p = pitch_tilted();
        send_tick(p[15:0], 16'sd0, 16'sd0, 11'sd0, 11'sd0, 1'b0);
    endtask

    task automatic test_random(input int count);
        int p, runs;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 199) == 0) begin
                // A tilt stretch, sometimes just short of tipping over.
                runs = $urandom_range(TILT_LIM - 3, TILT_LIM + 6);
                for (int j = 0; j < runs; j++) begin
                    p = pitch_tilted();
                    send_tick(p[15:0], rand_encoder(), rand_encoder(), 11'($urandom()),
                              11'($urandom()), 1'b1);
                end
                k += runs;
            end else begin
                send_mixed($urandom_range(0, 99));
            end
        end
    endtask

    // The receiver holds off for a long stretch while ticks keep coming.
    task automatic test_back_pressure();
        hold_request = 1'b1;
        burst_left = 30;
        for (int k = 0; k < 12; k++) send_mixed(20 + $urandom_range(0, 79));
    endtask

    initial begin
        gain_zero = 0; gain_bkp = 3328; gain_bki = 0; gain_bkd = 35840;
        gain_skp = 3584; gain_ski = 1024; gain_wkp = 5120; gain_wki = 25600;
        clear_loop_state();
        tilt_ticks = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_tip_over();
        test_random(250);
        test_back_pressure();
        load_gains($urandom_range(0, 46080) - 23040, $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
        test_random(250);
        load_gains(23040, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
        test_directed();
        test_random(200);
        load_gains(-23040, 0, 0, 0, 0, 0, 0, 0);
        test_tip_over();
        test_random(150);
        load_gains($urandom_range(0, 1000) - 500, 3328, 2000, 35840, 3584, 1024, 5120, 25600);
        test_random(350);
        wait_idle();
        repeat (20) @(negedge i_clk);

        $display("Ran %0d ticks over five register settings, %0d results checked, %0d tipped over.",
                 n_ticks, n_checked, n_tipped);
        $display("Covered tilt holds, tip-over and recovery, disables and a long output hold-off.");
        if (n_errors == 0 && drive_expq.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, drive_expq.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver stall pattern: three modes picked at random, one of which never stalls.
    initial begin : stall_pattern
        int mode, left, hold;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold = LONG_HOLD;
                while (hold > 0) begin
                    i_out_stall = 1'b1;
                    @(negedge i_clk);
                    hold--;
                end
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(50, 400);
            end
            left--;
            case (mode)
                0:       i_out_stall = 1'b0;
                1:       i_out_stall = ($urandom_range(0, 3) == 0);
                default: i_out_stall = ($urandom_range(0, 7) < 6);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_drive_out want;
        if (o_out_valid && !i_out_stall) begin
            if (drive_expq.size() == 0) begin
                $display("%0t: result with none expected: motor_a %0d motor_b %0d tipped %0b",
                         $time, o_motor_a, o_motor_b, o_tipped_over);
                n_errors++;
            end else begin
                want = drive_expq.pop_front();
                n_checked++;
                if (want.tipped) n_tipped++;
                if (o_motor_a !== want.motor_a) begin
                    $display("%0t: motor_a expected %0d actual %0d", $time, want.motor_a,
                             o_motor_a);
                    n_errors++;
                end
                if (o_motor_b !== want.motor_b) begin
                    $display("%0t: motor_b expected %0d actual %0d", $time, want.motor_b,
                             o_motor_b);
                    n_errors++;
                end
                if (o_tipped_over !== want.tipped) begin
                    $display("%0t: tipped_over expected %0b actual %0b", $time, want.tipped,
                             o_tipped_over);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("%0t: timeout with %0d results outstanding", $time, drive_expq.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

### files.f
sv/bcc_pkg.sv
sv/bcc_mul.sv
sv/bcc_div.sv
sv/balance_cascade_controller_core.sv
test/tb_balance_cascade_controller_core.sv
